// ----- src/battery_voltage_filtered_history_core_macros.svh -----
// Assertion macros for the battery voltage history core.
// No dependencies; included by modules that carry concurrent checks on clk and rst.
`ifndef BATTERY_VOLTAGE_FILTERED_HISTORY_CORE_MACROS_SVH
`define BATTERY_VOLTAGE_FILTERED_HISTORY_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define BVFH_ASSERT_IMPLY(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("bvfh: same-cycle check failed");
`define BVFH_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("bvfh: next-cycle check failed");
`else
`define BVFH_ASSERT_IMPLY(label, cond, prop)
`define BVFH_ASSERT_NEXT(label, cond, prop)
`endif
`endif

// ----- src/bvfh_pkg.sv -----
// Shared types and constants for the battery voltage history core.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package bvfh_pkg;

  localparam int DEFAULT_HISTORY_DEPTH = 32;
  localparam int DEFAULT_SAMPLE_BITS   = 10;
  localparam int DEFAULT_FRAC_BITS     = 16;

  localparam int TIME_BITS     = 32;
  localparam int BETA_BITS     = 16;
  localparam int SAMPLE_IV_BITS = 16;
  localparam int LOG_IV_BITS   = 32;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 32;
  localparam int CMD_BITS      = 2;

  // Filter starts at 511.0.
  localparam int FILTER_INIT_INT = 511;

  localparam logic [BETA_BITS-1:0]      BETA_RESET       = 16'd1638;
  localparam logic [SAMPLE_IV_BITS-1:0] SAMPLE_IV_RESET  = 16'd100;
  localparam logic [LOG_IV_BITS-1:0]    LOG_IV_RESET     = 32'd60000;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_UPDATE = 2'd0,
    CMD_READ   = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FILTER_ENABLE = 2'd0,
    CFG_FILTER_BETA   = 2'd1,
    CFG_SAMPLE_IV     = 2'd2,
    CFG_LOG_IV        = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic update;
    logic clear;
  } filt_ctrl_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

// ----- src/bvfh_cell.sv -----
// One history slot of the shifting history row.
// Depends on bvfh_pkg for the cell control struct.
`timescale 1ns / 1ps
module bvfh_cell #(
  parameter int WIDTH = bvfh_pkg::DEFAULT_SAMPLE_BITS
) (
  input  logic                 clk,
  input  bvfh_pkg::cell_ctrl_t ctrl,
  input  logic [WIDTH-1:0]     new_value,
  input  logic [WIDTH-1:0]     neighbor_value,
  output logic [WIDTH-1:0]     value
);
  import bvfh_pkg::*;

  // A full row shifts toward slot zero; otherwise only the next free slot loads.
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      value <= neighbor_value;
    end else if (ctrl.load) begin
      value <= new_value;
    end
  end

endmodule

// ----- src/bvfh_filter.sv -----
// Sample latch, sample timer and first-order low-pass filter.
// Depends on bvfh_pkg for widths and the filter control struct.
`timescale 1ns / 1ps
module bvfh_filter #(
  parameter int SAMPLE_BITS = bvfh_pkg::DEFAULT_SAMPLE_BITS,
  parameter int FRAC_BITS   = bvfh_pkg::DEFAULT_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  bvfh_pkg::filt_ctrl_t                ctrl,
  input  logic [bvfh_pkg::TIME_BITS-1:0]      current_time,
  input  logic [SAMPLE_BITS-1:0]              adc_sample,
  input  logic                                filter_enable,
  input  logic [bvfh_pkg::BETA_BITS-1:0]      filter_beta,
  input  logic [bvfh_pkg::SAMPLE_IV_BITS-1:0] sample_interval_ms,
  output logic [SAMPLE_BITS-1:0]              voltage
);
  import bvfh_pkg::*;

  localparam int FW = SAMPLE_BITS + FRAC_BITS;
  localparam int PW = BETA_BITS + 1 + FW + 1;

  logic [TIME_BITS-1:0]   sample_timer;
  logic [SAMPLE_BITS-1:0] latched_sample;
  logic [FW-1:0]          filter_value;

  logic [TIME_BITS-1:0]   elapsed;
  logic                   sample_due;
  logic [SAMPLE_BITS-1:0] latched_next;
  logic signed [FW:0]     diff;
  logic signed [PW-1:0]   beta_ext;
  logic signed [PW-1:0]   diff_ext;
  logic signed [PW-1:0]   prod;
  logic signed [PW-1:0]   step;
  logic [FW-1:0]          filter_next;

  assign elapsed      = current_time - sample_timer;
  assign sample_due   = elapsed >= {{(TIME_BITS-SAMPLE_IV_BITS){1'b0}}, sample_interval_ms};
  assign latched_next = sample_due ? adc_sample : latched_sample;

  // y + beta*(x - y) >> 16 with a floor shift equals the weighted sum form exactly.
  assign diff     = $signed({1'b0, latched_next, {FRAC_BITS{1'b0}}})
                  - $signed({1'b0, filter_value});
  assign beta_ext = $signed({{(PW-BETA_BITS){1'b0}}, filter_beta});
  assign diff_ext = $signed({{(PW-FW-1){diff[FW]}}, diff});
  assign prod     = beta_ext * diff_ext;
  assign step     = prod >>> BETA_BITS;
  assign filter_next = filter_value + step[FW-1:0];

  assign voltage = filter_enable ? filter_next[FW-1:FRAC_BITS] : latched_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_timer   <= '0;
      latched_sample <= '0;
      filter_value   <= {SAMPLE_BITS'(FILTER_INIT_INT), {FRAC_BITS{1'b0}}};
    end else begin
      if (ctrl.clear) begin
        sample_timer <= '0;
      end
      if (ctrl.update) begin
        if (sample_due) begin
          sample_timer   <= current_time;
          latched_sample <= adc_sample;
        end
        if (filter_enable) begin
          filter_value <= filter_next;
        end
      end
    end
  end

endmodule

// ----- src/battery_voltage_filtered_history_core.sv -----
// Battery voltage history core: configuration registers, log timer, history row
// of bvfh_cell slots, bvfh_filter front end and a two-deep result buffer.
// Depends on bvfh_pkg, bvfh_cell, bvfh_filter and the assertion macro header.
//
// Usage: each input transaction (in_valid, in_stall) carries a command: update
// with a time stamp and converter reading, read of one history slot, or clear.
// Every transaction yields exactly one result transaction (out_valid,
// out_stall) with the filtered voltage, a logged flag, the fill count and the
// read entry. Results are registered; one transaction can be accepted every
// cycle while in_stall is low, as the loops through the beta multiplier and
// the history row shift are combinational between their registers.
// While the receiver stalls, the output register holds its result and a skid
// register takes one more transaction; in_stall rises only when both are full.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect at the
// next edge; the user must make them while no transaction is outstanding (unenforced).
// Synchronous reset empties the result buffer, zeroes the history count and
// timers, and loads the register defaults and a filter value of 511.0.
`timescale 1ns / 1ps
module battery_voltage_filtered_history_core #(
  parameter int HISTORY_DEPTH = bvfh_pkg::DEFAULT_HISTORY_DEPTH,
  parameter int SAMPLE_BITS   = bvfh_pkg::DEFAULT_SAMPLE_BITS,
  parameter int FRAC_BITS     = bvfh_pkg::DEFAULT_FRAC_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [bvfh_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [bvfh_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [bvfh_pkg::CMD_BITS-1:0]      command,
  input  logic [bvfh_pkg::TIME_BITS-1:0]     current_time,
  input  logic [SAMPLE_BITS-1:0]             adc_sample,
  input  logic [$clog2(HISTORY_DEPTH)-1:0]   read_index,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [SAMPLE_BITS-1:0]             voltage_now,
  output logic                               entry_logged,
  output logic [$clog2(HISTORY_DEPTH+1)-1:0] fill_count,
  output logic [SAMPLE_BITS-1:0]             entry_value
);
  import bvfh_pkg::*;
  `include "battery_voltage_filtered_history_core_macros.svh"

  localparam int IW    = $clog2(HISTORY_DEPTH);
  localparam int CW    = $clog2(HISTORY_DEPTH+1);
  localparam int RES_W = SAMPLE_BITS + 1 + CW + SAMPLE_BITS;

  // Configuration registers.
  logic                      filter_enable;
  logic [BETA_BITS-1:0]      filter_beta;
  logic [SAMPLE_IV_BITS-1:0] sample_interval_ms;
  logic [LOG_IV_BITS-1:0]    log_interval_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_enable      <= 1'b0;
      filter_beta        <= BETA_RESET;
      sample_interval_ms <= SAMPLE_IV_RESET;
      log_interval_ms    <= LOG_IV_RESET;
    end else if (cfg_write) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FILTER_ENABLE: filter_enable      <= cfg_data[0];
        CFG_FILTER_BETA:   filter_beta        <= cfg_data[BETA_BITS-1:0];
        CFG_SAMPLE_IV:     sample_interval_ms <= cfg_data[SAMPLE_IV_BITS-1:0];
        CFG_LOG_IV:        log_interval_ms    <= cfg_data[LOG_IV_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Input decode.
  logic accept;
  logic is_update;
  logic is_read;
  logic is_clear;

  assign accept    = in_valid & ~in_stall;
  assign is_update = accept & (cmd_t'(command) == CMD_UPDATE);
  assign is_read   = accept & (cmd_t'(command) == CMD_READ);
  assign is_clear  = accept & (cmd_t'(command) == CMD_CLEAR);

  // Filter front end.
  filt_ctrl_t             filt_ctrl;
  logic [SAMPLE_BITS-1:0] voltage;

  assign filt_ctrl.update = is_update;
  assign filt_ctrl.clear  = is_clear;

  bvfh_filter #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_filter (
    .clk                (clk),
    .rst                (rst),
    .ctrl               (filt_ctrl),
    .current_time       (current_time),
    .adc_sample         (adc_sample),
    .filter_enable      (filter_enable),
    .filter_beta        (filter_beta),
    .sample_interval_ms (sample_interval_ms),
    .voltage            (voltage)
  );

  // Log timer and entry count.
  logic [TIME_BITS-1:0] log_timer;
  logic [CW-1:0]        entry_count;
  logic [CW-1:0]        entry_count_next;
  logic                 log_due;
  logic                 log_now;
  logic                 full;

  assign log_due = (current_time - log_timer) >= log_interval_ms;
  assign log_now = is_update & log_due;
  assign full    = entry_count == CW'(HISTORY_DEPTH);

  always_comb begin
    entry_count_next = entry_count;
    if (is_clear) begin
      entry_count_next = '0;
    end else if (log_now && !full) begin
      entry_count_next = entry_count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      log_timer   <= '0;
      entry_count <= '0;
    end else begin
      entry_count <= entry_count_next;
      if (is_clear) begin
        log_timer <= '0;
      end else if (log_now) begin
        log_timer <= current_time;
      end
    end
  end

  // History row: slot zero holds the oldest entry.
  logic [SAMPLE_BITS-1:0] slot [HISTORY_DEPTH];

  for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_slot
    cell_ctrl_t             cctrl;
    logic [SAMPLE_BITS-1:0] neighbor;

    assign cctrl.shift = log_now & full;
    assign cctrl.load  = log_now & ~full & (entry_count == CW'(i));
    if (i == HISTORY_DEPTH - 1) begin : g_last
      assign neighbor = voltage;
    end else begin : g_mid
      assign neighbor = slot[i+1];
    end

    bvfh_cell #(
      .WIDTH (SAMPLE_BITS)
    ) u_cell (
      .clk            (clk),
      .ctrl           (cctrl),
      .new_value      (voltage),
      .neighbor_value (neighbor),
      .value          (slot[i])
    );
  end

  // Slots at or beyond the count have never been written since the last clear
  // and read as zero.
  logic [SAMPLE_BITS-1:0] entry_read;

  always_comb begin
    entry_read = '0;
    if (is_read && (CW'(read_index) < entry_count)) begin
      entry_read = slot[read_index];
    end
  end

  logic [RES_W-1:0] res_new;

  assign res_new = {(is_update ? voltage : {SAMPLE_BITS{1'b0}}), log_now,
                    entry_count_next, entry_read};

  // Two-deep result buffer: output register plus skid register.
  logic             skid_valid;
  logic [RES_W-1:0] out_res;
  logic [RES_W-1:0] skid_res;
  logic             out_free;

  assign out_free = ~out_valid | ~out_stall;
  assign in_stall = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_res <= skid_valid ? skid_res : res_new;
    end else if (accept) begin
      skid_res <= res_new;
    end
  end

  assign voltage_now  = out_res[RES_W-1 -: SAMPLE_BITS];
  assign entry_logged = out_res[CW + SAMPLE_BITS];
  assign fill_count   = out_res[SAMPLE_BITS +: CW];
  assign entry_value  = out_res[SAMPLE_BITS-1:0];

  `BVFH_ASSERT_IMPLY(a_count_bound, 1'b1, entry_count <= CW'(HISTORY_DEPTH))
  `BVFH_ASSERT_IMPLY(a_skid_behind_out, skid_valid, out_valid)
  `BVFH_ASSERT_NEXT(a_clear_empties, is_clear, entry_count == '0)
  `BVFH_ASSERT_NEXT(a_log_grows, log_now && !full, entry_count == $past(entry_count) + CW'(1))
  `BVFH_ASSERT_IMPLY(a_logged_only_update, log_now, is_update)

endmodule

// ----- test/battery_voltage_filtered_history_core_tb.sv -----
// Self-checking testbench for battery_voltage_filtered_history_core.
// It drives commands under random backpressure and checks every result against a local predictor.
// Depends on bvfh_pkg and the core RTL.
`timescale 1ns / 1ps
module battery_voltage_filtered_history_core_tb;
  import bvfh_pkg::*;

  localparam int HIST_DEPTH = DEFAULT_HISTORY_DEPTH;
  localparam int SMP_BITS   = DEFAULT_SAMPLE_BITS;
  localparam int FRAC       = DEFAULT_FRAC_BITS;
  localparam int IDX_BITS   = $clog2(HIST_DEPTH);
  localparam int FILL_BITS  = $clog2(HIST_DEPTH + 1);
  localparam int FILT_BITS  = SMP_BITS + FRAC;
  localparam int STALL_LIMIT = 2000;
  localparam int SHOWN_MISMATCHES = 10;
  localparam logic [CMD_BITS-1:0] CMD_RESERVED = 2'd3;
  localparam logic [63:0] BETA_ONE = 64'd65536;

  typedef struct packed {
    logic [CMD_BITS-1:0]  command;
    logic [TIME_BITS-1:0] now;
    logic [SMP_BITS-1:0]  adc;
    logic [IDX_BITS-1:0]  idx;
  } cmd_item_t;

  typedef struct packed {
    logic [SMP_BITS-1:0]  volt;
    logic                 logged;
    logic [FILL_BITS-1:0] fill;
    logic [SMP_BITS-1:0]  entry;
  } hist_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CMD_BITS-1:0] command = '0;
  logic [TIME_BITS-1:0] current_time = '0;
  logic [SMP_BITS-1:0] adc_sample = '0;
  logic [IDX_BITS-1:0] read_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [SMP_BITS-1:0] voltage_now;
  logic entry_logged;
  logic [FILL_BITS-1:0] fill_count;
  logic [SMP_BITS-1:0] entry_value;

  battery_voltage_filtered_history_core #(
    .HISTORY_DEPTH(HIST_DEPTH),
    .SAMPLE_BITS(SMP_BITS),
    .FRAC_BITS(FRAC)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .command(command),
    .current_time(current_time),
    .adc_sample(adc_sample),
    .read_index(read_index),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .voltage_now(voltage_now),
    .entry_logged(entry_logged),
    .fill_count(fill_count),
    .entry_value(entry_value)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Predictor copy of the configuration and the block state.
  logic                 cfg_en;
  logic [BETA_BITS-1:0] cfg_beta;
  logic [SAMPLE_IV_BITS-1:0] cfg_siv;
  logic [LOG_IV_BITS-1:0] cfg_liv;
  logic [SMP_BITS-1:0]  hist_mem [HIST_DEPTH];
  int                   hist_fill;
  logic [TIME_BITS-1:0] smp_timer;
  logic [TIME_BITS-1:0] log_tmr;
  logic [SMP_BITS-1:0]  latched;
  logic [FILT_BITS-1:0] filt_q;

  cmd_item_t    queued_commands[$];
  hist_result_t pending_results[$];
  int issued_count = 0;
  int checked_count = 0;
  int error_count = 0;
  int mismatch_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stuck_cycles = 0;
  logic [TIME_BITS-1:0] gen_time = '0;

  function automatic void clear_store();
    for (int k = 0; k < HIST_DEPTH; k++) hist_mem[k] = '0;
    hist_fill = 0;
    smp_timer = '0;
    log_tmr = '0;
  endfunction

  function automatic hist_result_t next_history_result(cmd_item_t it);
    hist_result_t r;
    logic [TIME_BITS-1:0] elapsed;
    logic [63:0] b, y, x, acc;
    r = '0;
    case (it.command)
      CMD_UPDATE: begin
        elapsed = it.now - smp_timer;
        if (elapsed >= cfg_siv) begin
          smp_timer = it.now;
          latched = it.adc;
        end
        r.volt = latched;
        if (cfg_en) begin
          b = 64'(cfg_beta);
          y = 64'(filt_q);
          x = 64'(latched);
          acc = (BETA_ONE - b) * y + b * (x << FRAC);
          acc = acc >> 16;
          filt_q = acc[FILT_BITS-1:0];
          r.volt = filt_q[FRAC +: SMP_BITS];
        end
        elapsed = it.now - log_tmr;
        if (elapsed >= cfg_liv) begin
          log_tmr = it.now;
          if (hist_fill < HIST_DEPTH) begin
            hist_mem[IDX_BITS'(hist_fill)] = r.volt;
            hist_fill++;
          end else begin
            // Full store slides: oldest entry drops out at index zero.
            for (int k = 0; k < HIST_DEPTH - 1; k++) hist_mem[k] = hist_mem[k + 1];
            hist_mem[HIST_DEPTH - 1] = r.volt;
          end
          r.logged = 1'b1;
        end
      end
      CMD_READ: begin
        if (it.idx < HIST_DEPTH) r.entry = hist_mem[it.idx];
      end
      CMD_CLEAR: begin
        clear_store();
      end
      default: begin
      end
    endcase
    r.fill = FILL_BITS'(hist_fill);
    return r;
  endfunction

  task automatic push_item(input logic [CMD_BITS-1:0] c, input logic [TIME_BITS-1:0] t,
                           input logic [SMP_BITS-1:0] a, input logic [IDX_BITS-1:0] i);
    queued_commands.push_back('{command: c, now: t, adc: a, idx: i});
    issued_count++;
  endtask

  task automatic write_config(input logic en, input logic [BETA_BITS-1:0] beta,
                              input logic [SAMPLE_IV_BITS-1:0] siv,
                              input logic [LOG_IV_BITS-1:0] liv);
    cfg_en = en;
    cfg_beta = beta;
    cfg_siv = siv;
    cfg_liv = liv;
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= CFG_FILTER_ENABLE;
    cfg_data <= CFG_DATA_BITS'(en);
    @(posedge clk);
    cfg_index <= CFG_FILTER_BETA;
    cfg_data <= CFG_DATA_BITS'(beta);
    @(posedge clk);
    cfg_index <= CFG_SAMPLE_IV;
    cfg_data <= CFG_DATA_BITS'(siv);
    @(posedge clk);
    cfg_index <= CFG_LOG_IV;
    cfg_data <= liv;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic wait_drained();
    while (checked_count != issued_count) @(posedge clk);
  endtask

  task automatic gen_random(input int n, input int step_max,
                            input logic [TIME_BITS-1:0] siv, input logic [TIME_BITS-1:0] liv);
    int pick;
    logic [CMD_BITS-1:0] c;
    logic [SMP_BITS-1:0] a;
    for (int n_done = 0; n_done < n; n_done++) begin
      // Time mostly creeps forward, sometimes lands on an interval boundary or jumps anywhere.
      pick = $urandom_range(0, 99);
      if (pick < 3) gen_time = $urandom;
      else if (pick < 8) gen_time += siv;
      else if (pick < 11) gen_time += liv;
      else gen_time += $urandom_range(0, step_max);
      pick = $urandom_range(0, 99);
      if (pick < 74) c = CMD_UPDATE;
      else if (pick < 95) c = CMD_READ;
      else if (pick < 96) c = CMD_CLEAR;
      else c = CMD_RESERVED;
      pick = $urandom_range(0, 9);
      if (pick == 0) a = '0;
      else if (pick == 1) a = '1;
      else a = SMP_BITS'($urandom);
      push_item(c, gen_time, a, IDX_BITS'($urandom_range(0, HIST_DEPTH - 1)));
    end
  endtask

  // Driver: holds a transaction until it is taken and predicts it at acceptance.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        pending_results.push_back(next_history_result('{command: command, now: current_time,
                                                        adc: adc_sample, idx: read_index}));
      end
      if (!in_valid || !in_stall) begin
        if (queued_commands.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cmd_item_t nx;
          nx = queued_commands.pop_front();
          command <= nx.command;
          current_time <= nx.now;
          adc_sample <= nx.adc;
          read_index <= nx.idx;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Monitor: every accepted result is matched against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      hist_result_t got, want;
      got = '{volt: voltage_now, logged: entry_logged, fill: fill_count, entry: entry_value};
      if (pending_results.size() == 0) begin
        error_count++;
        mismatch_count++;
        if (mismatch_count <= SHOWN_MISMATCHES)
          $display("unexpected result: volt=%0d logged=%0d fill=%0d entry=%0d",
                   got.volt, got.logged, got.fill, got.entry);
      end else begin
        want = pending_results.pop_front();
        checked_count++;
        if (got.volt !== want.volt || got.logged !== want.logged ||
            got.fill !== want.fill || got.entry !== want.entry) begin
          error_count++;
          mismatch_count++;
          if (mismatch_count <= SHOWN_MISMATCHES) begin
            $display("mismatch at result %0d: expected volt=%0d logged=%0d fill=%0d entry=%0d",
                     checked_count, want.volt, want.logged, want.fill, want.entry);
            $display("  actual volt=%0d logged=%0d fill=%0d entry=%0d",
                     got.volt, got.logged, got.fill, got.entry);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles == STALL_LIMIT) begin
        $display("battery_voltage_filtered_history_core_tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    logic [BETA_BITS-1:0] rnd_beta;
    logic [SAMPLE_IV_BITS-1:0] rnd_siv;
    logic [LOG_IV_BITS-1:0] rnd_liv;
    cfg_en = 1'b0;
    cfg_beta = BETA_RESET;
    cfg_siv = SAMPLE_IV_RESET;
    cfg_liv = LOG_IV_RESET;
    clear_store();
    latched = '0;
    filt_q = FILT_BITS'(FILTER_INIT_INT * (1 << FRAC));
    send_idle_pct = 17;
    recv_idle_pct = 83;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part: zero intervals so every update latches and logs, full-scale beta.
    write_config(1'b1, 16'hFFFF, 16'd0, 32'd0);
    push_item(CMD_READ, 32'd0, 10'd0, 5'd0);
    push_item(CMD_READ, 32'd0, 10'd0, 5'd31);
    push_item(CMD_UPDATE, 32'd0, 10'h3FF, 5'd0);
    push_item(CMD_UPDATE, 32'd0, 10'h000, 5'd31);
    push_item(CMD_UPDATE, 32'hFFFF_FFFF, 10'h3FF, 5'd0);
    push_item(CMD_UPDATE, 32'd1, 10'h155, 5'd21);
    push_item(CMD_UPDATE, 32'd2, 10'h2AA, 5'd10);
    push_item(CMD_RESERVED, 32'hFFFF_FFFF, 10'h3FF, 5'd31);
    for (int k = 0; k < 5; k++) push_item(CMD_READ, 32'd3, 10'd0, IDX_BITS'(k));
    push_item(CMD_READ, 32'd3, 10'd0, 5'd31);
    push_item(CMD_CLEAR, 32'hFFFF_FFFF, 10'h3FF, 5'd31);
    push_item(CMD_READ, 32'd4, 10'd0, 5'd0);
    push_item(CMD_UPDATE, 32'd5, 10'd512, 5'd0);
    push_item(CMD_READ, 32'd6, 10'd0, 5'd0);
    push_item(CMD_READ, 32'd6, 10'd0, 5'd1);
    wait_drained();

    write_config(1'b1, BETA_RESET, SAMPLE_IV_RESET, 32'd150);
    gen_random(322, 120, TIME_BITS'(SAMPLE_IV_RESET), 32'd150);
    wait_drained();
    write_config(1'b0, 16'd1, 16'd0, 32'd0);
    gen_random(322, 50, 32'd0, 32'd0);
    wait_drained();

    send_idle_pct = 83;
    recv_idle_pct = 17;
    write_config(1'b1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    gen_random(322, 70000, 32'h0000_FFFF, 32'hFFFF_FFFF);
    wait_drained();
    // A zero beta leaves the filter frozen while samples keep being latched.
    write_config(1'b1, 16'd0, 16'd7, 32'd40);
    gen_random(322, 30, 32'd7, 32'd40);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    rnd_beta = BETA_BITS'($urandom_range(1, 65535));
    rnd_siv = SAMPLE_IV_BITS'($urandom_range(0, 50));
    rnd_liv = LOG_IV_BITS'($urandom_range(0, 300));
    write_config(1'b1, rnd_beta, rnd_siv, rnd_liv);
    gen_random(322, 100, TIME_BITS'(rnd_siv), rnd_liv);
    wait_drained();
    write_config(1'b0, 16'd40000, 16'd20, 32'd0);
    gen_random(322, 40, 32'd20, 32'd0);
    wait_drained();

    repeat (4) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("battery_voltage_filtered_history_core_tb: done, clean");
    end else begin
      $display("battery_voltage_filtered_history_core_tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+src
src/bvfh_pkg.sv
src/bvfh_cell.sv
src/bvfh_filter.sv
src/battery_voltage_filtered_history_core.sv
test/battery_voltage_filtered_history_core_tb.sv
